@@ rtl/core/fbmt_pkg.sv @@
package fbmt_pkg;

	// map geometry
	localparam int unsigned MAX_BLOCKS = 4096;
	localparam int unsigned BLK_W = 12;
	localparam int unsigned CNT_W = 13;
	localparam int unsigned SEC_W = 22;
	localparam int unsigned OFFS_W = 10;
	localparam int unsigned QDEPTH = 2;

	// record and register limits
	localparam logic [15:0] SIG_VALID = 16'h00FF;
	localparam logic [31:0] CLAIM_ERASED = 32'hFFFF_FFFF;
	localparam logic [3:0] LOG2_LIMIT = 4'd10;
	localparam logic [CNT_W-1:0] BLOCKS_LIMIT = CNT_W'(MAX_BLOCKS);

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_SCAN = 2'd1;
	localparam logic [1:0] CMD_XLATE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_LOG2 = 2'd0;
	localparam logic [1:0] CFG_PAGES = 2'd1;
	localparam logic [1:0] CFG_BLOCKS = 2'd2;

	// result status codes
	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_BAD = 4'd1;
	localparam logic [3:0] ST_READERR = 4'd2;
	localparam logic [3:0] ST_SIGNATURE = 4'd3;
	localparam logic [3:0] ST_LASTPAGE = 4'd4;
	localparam logic [3:0] ST_ERASED = 4'd5;
	localparam logic [3:0] ST_BEYOND = 4'd6;
	localparam logic [3:0] ST_DUPLICATE = 4'd7;
	localparam logic [3:0] ST_RANGE = 4'd8;
	localparam logic [3:0] ST_UNMAPPED = 4'd9;
	localparam logic [3:0] ST_NOMAP = 4'd10;

	// work kinds handed from front to back
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_FINAL = 2'd1,
		OP_SCAN = 2'd2,
		OP_XLATE = 2'd3
	} op_kind_t;

	typedef struct packed {
		logic [3:0] log2;
		logic [10:0] pages;
		logic [CNT_W-1:0] blocks;
	} cfg_t;

	typedef struct packed {
		op_kind_t kind;
		logic [3:0] status;
		logic out_of_range;
		logic [BLK_W-1:0] addr;
		logic [BLK_W-1:0] pblk;
		logic [OFFS_W-1:0] offs;
		logic [3:0] shift;
	} op_t;

	typedef struct packed {
		logic [3:0] status;
		logic [BLK_W-1:0] owner;
		logic [SEC_W-1:0] psec;
		logic [CNT_W-1:0] found;
	} res_t;

endpackage

@@ rtl/core/flash_block_map_translate.sv @@
// NAND logical-to-physical block map with sector translation.
// Input side is a queue: an item (cmd and its fields) is taken on a clock
// edge with push high and full low. Results come out of a queue: the oldest
// result sits on status/owner_block/physical_sector/blocks_found while empty
// is low and is taken on an edge with pop high. Every item gives one result.
// A front stage classifies items into a two-entry queue; the back stage owns
// the map memory (one read port, one write port, registered read).
// Scan and translate items that reach the map pass through the READ state
// (read, then optional write: a scan that finds a free entry claims it);
// rejected records, cmd 3 and translates that fail before the map lookup
// are answered without the READ state. A clear item answers at once and
// then sweeps all 4096 map entries, one entry per cycle, before the next
// item is started. After reset the same clearing pass runs and full stays
// high until it ends; configuration writes are taken at any time.
// When the receiver stalls, the result register holds, the back stage
// takes no new item (a running map sweep goes on), and full rises once
// the two-entry queue fills.
module flash_block_map_translate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  cmd,
	input  logic [11:0] phys_block,
	input  logic        block_bad,
	input  logic        spare_read_error,
	input  logic [15:0] signature,
	input  logic [15:0] end_page,
	input  logic [31:0] claimed_logical,
	input  logic [21:0] sector,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  status,
	output logic [11:0] owner_block,
	output logic [21:0] physical_sector,
	output logic [12:0] blocks_found,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	import fbmt_pkg::*;

	cfg_t cfg_q;
	op_t front_op;
	op_t q_op;
	logic q_full;
	logic q_empty;
	logic q_pop;
	logic sweeping;
	logic res_valid;
	res_t res;
	logic accept;

	assign full = q_full || sweeping;
	assign accept = push && !full;
	assign empty = !res_valid;
	assign status = res.status;
	assign owner_block = res.owner;
	assign physical_sector = res.psec;
	assign blocks_found = res.found;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.log2 <= 4'd8;
			cfg_q.pages <= 11'd64;
			cfg_q.blocks <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOG2: cfg_q.log2 <= cfg_data[3:0];
				CFG_PAGES: cfg_q.pages <= cfg_data[10:0];
				CFG_BLOCKS: cfg_q.blocks <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	fbmt_front u_front (
		.cfg             (cfg_q),
		.cmd             (cmd),
		.phys_block      (phys_block),
		.block_bad       (block_bad),
		.spare_read_error(spare_read_error),
		.signature       (signature),
		.end_page        (end_page),
		.claimed_logical (claimed_logical),
		.sector          (sector),
		.op              (front_op)
	);

	fbmt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.wr_op  (front_op),
		.rd_en  (q_pop),
		.rd_op  (q_op),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	fbmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_op     (q_op),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.sweeping (sweeping),
		.pop      (pop),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

@@ rtl/core/fbmt_ram.sv @@
module fbmt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/fbmt_front.sv @@
module fbmt_front (
	input  fbmt_pkg::cfg_t                cfg,
	input  logic [1:0]                    cmd,
	input  logic [11:0]                   phys_block,
	input  logic                          block_bad,
	input  logic                          spare_read_error,
	input  logic [15:0]                   signature,
	input  logic [15:0]                   end_page,
	input  logic [31:0]                   claimed_logical,
	input  logic [21:0]                   sector,
	output fbmt_pkg::op_t                 op
);

	import fbmt_pkg::*;

	logic [3:0] eff_log2;
	logic [CNT_W-1:0] eff_blocks;
	logic [SEC_W:0] sec_limit;
	logic [SEC_W-1:0] lblk_full;
	logic [OFFS_W-1:0] offs_mask;

	// clamp log2 and block count configuration to their working range
	always_comb begin
		eff_log2 = (cfg.log2 > LOG2_LIMIT) ? LOG2_LIMIT : cfg.log2;
		eff_blocks = (cfg.blocks > BLOCKS_LIMIT) ? BLOCKS_LIMIT : cfg.blocks;
	end

	// sector split and range bound
	always_comb begin
		sec_limit = (SEC_W+1)'(eff_blocks) << eff_log2;
		lblk_full = sector >> eff_log2;
		offs_mask = ~({OFFS_W{1'b1}} << eff_log2);
	end

	// classify the item; checks that need no map state finish here
	always_comb begin
		op = '0;
		op.pblk = phys_block;
		op.shift = eff_log2;
		op.offs = sector[OFFS_W-1:0] & offs_mask;
		op.out_of_range = ({1'b0, sector} >= sec_limit);
		case (cmd)
			CMD_CLEAR: begin
				op.kind = OP_CLEAR;
			end
			CMD_SCAN: begin
				op.kind = OP_FINAL;
				op.addr = claimed_logical[BLK_W-1:0];
				if (block_bad) begin
					op.status = ST_BAD;
				end else if (spare_read_error) begin
					op.status = ST_READERR;
				end else if (signature != SIG_VALID) begin
					op.status = ST_SIGNATURE;
				end else if (end_page >= {5'b0, cfg.pages}) begin
					op.status = ST_LASTPAGE;
				end else if (claimed_logical == CLAIM_ERASED) begin
					op.status = ST_ERASED;
				end else if (claimed_logical >= {19'b0, eff_blocks}) begin
					op.status = ST_BEYOND;
				end else begin
					op.kind = OP_SCAN;
				end
			end
			CMD_XLATE: begin
				op.kind = OP_XLATE;
				op.addr = lblk_full[BLK_W-1:0];
			end
			default: begin
				op.kind = OP_FINAL;
				op.status = ST_OK;
			end
		endcase
	end

endmodule

@@ rtl/core/fbmt_queue.sv @@
module fbmt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  fbmt_pkg::op_t wr_op,
	input  logic          rd_en,
	output fbmt_pkg::op_t rd_op,
	output logic          q_full,
	output logic          q_empty
);

	import fbmt_pkg::*;

	op_t slot_q [QDEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign q_full = (cnt_q == 2'(QDEPTH));
	assign q_empty = (cnt_q == 2'd0);
	assign rd_op = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/fbmt_back.sv @@
module fbmt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fbmt_pkg::op_t q_op,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          sweeping,
	input  logic          pop,
	output logic          res_valid,
	output fbmt_pkg::res_t res
);

	import fbmt_pkg::*;

	typedef enum logic [2:0] {
		S_SWEEP = 3'b001,
		S_IDLE = 3'b010,
		S_READ = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic [BLK_W-1:0] sweep_addr_q;
	logic [CNT_W-1:0] found_q;
	logic [CNT_W-1:0] found_d;
	op_t op_q;
	logic out_valid_q;
	res_t out_q;

	logic out_free;
	logic take;
	logic load;
	res_t res_d;
	logic ram_we;
	logic [BLK_W-1:0] ram_waddr;
	logic [BLK_W:0] ram_wdata;
	logic [BLK_W:0] ram_rdata;
	logic ent_valid;
	logic [BLK_W-1:0] ent_blk;
	logic [SEC_W-1:0] psec;

	assign out_free = !out_valid_q || pop;
	assign take = (state_q == S_IDLE) && !q_empty && out_free;
	assign q_pop = take;
	assign sweeping = (state_q == S_SWEEP);
	assign res_valid = out_valid_q;
	assign res = out_q;

	assign ent_valid = ram_rdata[BLK_W];
	assign ent_blk = ram_rdata[BLK_W-1:0];
	assign psec = (SEC_W'(ent_blk) << op_q.shift) | SEC_W'(op_q.offs);

	// map memory: valid bit over physical block
	fbmt_ram #(
		.WIDTH(BLK_W + 1),
		.DEPTH(MAX_BLOCKS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(q_op.addr),
		.rdata(ram_rdata)
	);

	// sequencing, map update and result build
	always_comb begin
		state_d = state_q;
		found_d = found_q;
		load = 1'b0;
		res_d = '0;
		res_d.found = found_q;
		ram_we = 1'b0;
		ram_waddr = sweep_addr_q;
		ram_wdata = '0;
		case (state_q)
			S_SWEEP: begin
				ram_we = 1'b1;
				if (sweep_addr_q == {BLK_W{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					case (q_op.kind)
						OP_CLEAR: begin
							load = 1'b1;
							found_d = '0;
							res_d.found = '0;
							state_d = S_SWEEP;
						end
						OP_FINAL: begin
							load = 1'b1;
							res_d.status = q_op.status;
						end
						OP_SCAN: begin
							state_d = S_READ;
						end
						OP_XLATE: begin
							if (found_q == '0) begin
								load = 1'b1;
								res_d.status = ST_NOMAP;
							end else if (q_op.out_of_range) begin
								load = 1'b1;
								res_d.status = ST_RANGE;
							end else begin
								state_d = S_READ;
							end
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				load = 1'b1;
				state_d = S_IDLE;
				if (op_q.kind == OP_SCAN) begin
					if (ent_valid) begin
						res_d.status = ST_DUPLICATE;
						res_d.owner = ent_blk;
					end else begin
						ram_we = 1'b1;
						ram_waddr = op_q.addr;
						ram_wdata = {1'b1, op_q.pblk};
						found_d = found_q + CNT_W'(1);
						res_d.status = ST_OK;
						res_d.owner = op_q.pblk;
						res_d.found = found_q + CNT_W'(1);
					end
				end else begin
					if (!ent_valid) begin
						res_d.status = ST_UNMAPPED;
					end else begin
						res_d.status = ST_OK;
						res_d.owner = ent_blk;
						res_d.psec = psec;
					end
				end
			end
			default: begin
				state_d = S_SWEEP;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_addr_q <= '0;
			found_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			found_q <= found_d;
			if (state_q == S_SWEEP) begin
				sweep_addr_q <= sweep_addr_q + BLK_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= q_op;
		end
		if (load) begin
			out_q <= res_d;
		end
	end

endmodule
